FILE: src/ubd_pkg.sv
// ----------------------------------------------------------------------------
// ubd_pkg: shared constants for the baud divisor search
// Field widths, oversampling range and the clock reset value used by the top module and the bench.
// ----------------------------------------------------------------------------
package ubd_pkg;

  // field widths
  localparam int unsigned CLK_W   = 27;
  localparam int unsigned BAUD_W  = 24;
  localparam int unsigned OSR_W   = 5;
  localparam int unsigned RATIO_W = 6;
  localparam int unsigned DIV_OUT_W = 13;
  localparam int unsigned ERR_OUT_W = 24;

  // divisor of the first division: baud * ratio
  localparam int unsigned D1_W = BAUD_W + RATIO_W;

  // oversampling range
  localparam logic [OSR_W-1:0] OSR_FIRST = 5'd7;
  localparam logic [OSR_W-1:0] OSR_LAST  = 5'd31;

  // clock register reset value
  localparam logic [CLK_W-1:0] CLK_RESET = 27'd40000000;

endpackage

FILE: src/ubd_div_cell.sv
// ----------------------------------------------------------------------------
// ubd_div_cell: one restoring division step
// Resolves one quotient bit and hands remainder, quotient and payload on.
// ----------------------------------------------------------------------------
module ubd_div_cell #(
  parameter int unsigned NW  = 27,
  parameter int unsigned DW  = 30,
  parameter int unsigned PW  = 8,
  parameter int unsigned BIT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          v_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  input  logic [DW-1:0] r_i,
  input  logic [NW-1:0] q_i,
  input  logic [PW-1:0] p_i,
  output logic          v_o,
  output logic [NW-1:0] n_o,
  output logic [DW-1:0] d_o,
  output logic [DW-1:0] r_o,
  output logic [NW-1:0] q_o,
  output logic [PW-1:0] p_o
);

  logic [DW:0]   t;
  logic          ge;
  logic [DW:0]   diff;
  logic [DW-1:0] r_d;
  logic [NW-1:0] q_d;
  logic          v_q;
  logic [NW-1:0] n_q;
  logic [DW-1:0] d_q;
  logic [DW-1:0] r_q;
  logic [NW-1:0] q_q;
  logic [PW-1:0] p_q;

  // shift in the next dividend bit and try to subtract
  always_comb begin
    t    = {r_i, n_i[BIT]};
    ge   = (t >= {1'b0, d_i});
    diff = t - {1'b0, d_i};
    r_d  = ge ? diff[DW-1:0] : t[DW-1:0];
    q_d  = q_i;
    q_d[BIT] = ge;
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= v_i;
    end
  end

  // data registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= n_i;
      d_q <= d_i;
      r_q <= r_d;
      q_q <= q_d;
      p_q <= p_i;
    end
  end

  assign v_o = v_q;
  assign n_o = n_q;
  assign d_o = d_q;
  assign r_o = r_q;
  assign q_o = q_q;
  assign p_o = p_q;

endmodule

FILE: src/ubd_div_chain.sv
// ----------------------------------------------------------------------------
// ubd_div_chain: row of division cells
// One cell per quotient bit, most significant first; one new division per cycle while en_i is high.
// ----------------------------------------------------------------------------
module ubd_div_chain #(
  parameter int unsigned NW = 27,
  parameter int unsigned DW = 30,
  parameter int unsigned PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          v_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  input  logic [PW-1:0] p_i,
  output logic          v_o,
  output logic [NW-1:0] q_o,
  output logic [PW-1:0] p_o
);

  logic [NW:0]          v;
  logic [NW:0][NW-1:0]  n;
  logic [NW:0][DW-1:0]  d;
  logic [NW:0][DW-1:0]  r;
  logic [NW:0][NW-1:0]  q;
  logic [NW:0][PW-1:0]  p;

  // chain entry
  assign v[0] = v_i;
  assign n[0] = n_i;
  assign d[0] = d_i;
  assign r[0] = '0;
  assign q[0] = '0;
  assign p[0] = p_i;

  // cells
  for (genvar i = 0; i < NW; i++) begin : g_cell
    ubd_div_cell #(
      .NW  (NW),
      .DW  (DW),
      .PW  (PW),
      .BIT (NW - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .v_i    (v[i]),
      .n_i    (n[i]),
      .d_i    (d[i]),
      .r_i    (r[i]),
      .q_i    (q[i]),
      .p_i    (p[i]),
      .v_o    (v[i+1]),
      .n_o    (n[i+1]),
      .d_o    (d[i+1]),
      .r_o    (r[i+1]),
      .q_o    (q[i+1]),
      .p_o    (p[i+1])
    );
  end

  assign v_o = v[NW];
  assign q_o = q[NW];
  assign p_o = p[NW];

endmodule

FILE: src/uart_baud_divisor_search.sv
// ----------------------------------------------------------------------------
// uart_baud_divisor_search: best oversampling setting and divisor for a baud rate
// Tries oversampling settings 7..31 through two rows of division cells and
// keeps the candidate with the smallest rate error (lower setting on a tie).
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  s_axis   in   tdata: baud_rate[23:0]
//  m_axis   out  tdata: osr_setting, divisor, rate_error; tuser: found
//  cfg      in   wr_data: clock_hz[26:0]
//
//  one candidate enters the division rows per cycle while the pipeline is not
//  held; the next item is taken in the last issue cycle.
//  a result passes the issue register, the first row of 27 cell stages, the
//  check register, the second row of 27 cell stages, the error register and
//  the output register. reset clears all valid flags and sets clock_hz to 40000000.
//  the whole pipeline holds only while a finished result waits on m_axis.
// ----------------------------------------------------------------------------
module uart_baud_divisor_search #(
  parameter int unsigned DIVISOR_BITS = 13
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_en_i,
  input  logic [ubd_pkg::CLK_W-1:0] cfg_wr_data_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [23:0]               s_axis_tdata,   // baud_rate[23:0]
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // osr_setting[4:0], divisor[17:5], rate_error[41:18], zero pad[47:42]
  output logic [47:0]               m_axis_tdata,
  output logic                      m_axis_tuser     // found
);

  import ubd_pkg::*;

  localparam int unsigned DB  = DIVISOR_BITS;
  localparam int unsigned D2W = DB + RATIO_W;
  localparam int unsigned P1W = 2 + OSR_W + BAUD_W;
  localparam int unsigned P2W = 3 + OSR_W + DB + BAUD_W;

  // configuration register
  logic [CLK_W-1:0] clk_hz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= CLK_RESET;
    end else if (cfg_wr_en_i) begin
      clk_hz_q <= cfg_wr_data_i;
    end
  end

  // pipeline advance
  logic en;
  logic e_v_q, e_last_q;
  logic out_v_q;

  assign en = !(e_v_q && e_last_q && out_v_q && !m_axis_tready);

  // candidate issue
  logic              busy_q;
  logic [OSR_W-1:0]  osr_q;
  logic [BAUD_W-1:0] baud_q;
  logic              s_acc;
  logic              iss_last;

  assign iss_last      = (osr_q == OSR_LAST);
  assign s_axis_tready = en && (!busy_q || iss_last);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      osr_q  <= OSR_FIRST;
    end else if (en) begin
      if (s_acc) begin
        busy_q <= 1'b1;
        osr_q  <= OSR_FIRST;
      end else if (busy_q) begin
        busy_q <= !iss_last;
        osr_q  <= osr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      baud_q <= s_axis_tdata[BAUD_W-1:0];
    end
  end

  // issue register: divisor baud * ratio
  logic              i_v_q;
  logic [D1_W-1:0]   i_d_q;
  logic [P1W-1:0]    i_p_q;
  logic [RATIO_W-1:0] ratio;

  assign ratio = {1'b0, osr_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_v_q <= 1'b0;
    end else if (en) begin
      i_v_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_d_q <= baud_q * ratio;
      i_p_q <= {iss_last, osr_q == OSR_FIRST, osr_q, baud_q};
    end
  end

  // first row: divisor = clock / (baud * ratio)
  logic             c1_v;
  logic [CLK_W-1:0] c1_q;
  logic [P1W-1:0]   c1_p;

  ubd_div_chain #(
    .NW (CLK_W),
    .DW (D1_W),
    .PW (P1W)
  ) u_div1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (i_v_q),
    .n_i    (clk_hz_q),
    .d_i    (i_d_q),
    .p_i    (i_p_q),
    .v_o    (c1_v),
    .q_o    (c1_q),
    .p_o    (c1_p)
  );

  // divisor check and divisor * ratio
  logic              m_v_q;
  logic [D2W-1:0]    m_d_q;
  logic [P2W-1:0]    m_p_q;
  logic              c1_ok;
  logic [OSR_W-1:0]  c1_osr;
  logic [RATIO_W-1:0] c1_ratio;

  assign c1_osr   = c1_p[BAUD_W +: OSR_W];
  assign c1_ratio = {1'b0, c1_osr} + 1'b1;
  assign c1_ok    = (c1_q != '0) && (c1_q[CLK_W-1:DB] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= c1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_d_q <= c1_q[DB-1:0] * c1_ratio;
      m_p_q <= {c1_p[P1W-1 -: 2], c1_ok, c1_osr, c1_q[DB-1:0], c1_p[BAUD_W-1:0]};
    end
  end

  // second row: achieved = clock / (divisor * ratio)
  logic             c2_v;
  logic [CLK_W-1:0] c2_q;
  logic [P2W-1:0]   c2_p;

  ubd_div_chain #(
    .NW (CLK_W),
    .DW (D2W),
    .PW (P2W)
  ) u_div2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (m_v_q),
    .n_i    (clk_hz_q),
    .d_i    (m_d_q),
    .p_i    (m_p_q),
    .v_o    (c2_v),
    .q_o    (c2_q),
    .p_o    (c2_p)
  );

  // rate error
  logic [BAUD_W-1:0] c2_baud;
  logic [CLK_W-1:0]  c2_baud_x;
  logic              e_first_q, e_ok_q;
  logic [OSR_W-1:0]  e_osr_q;
  logic [DB-1:0]     e_div_q;
  logic [CLK_W-1:0]  e_err_q;

  assign c2_baud   = c2_p[BAUD_W-1:0];
  assign c2_baud_x = {{(CLK_W-BAUD_W){1'b0}}, c2_baud};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (en) begin
      e_v_q <= c2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_err_q   <= (c2_baud_x >= c2_q) ? (c2_baud_x - c2_q) : (c2_q - c2_baud_x);
      e_last_q  <= c2_p[P2W-1];
      e_first_q <= c2_p[P2W-2];
      e_ok_q    <= c2_p[P2W-3];
      e_osr_q   <= c2_p[BAUD_W + DB +: OSR_W];
      e_div_q   <= c2_p[BAUD_W +: DB];
    end
  end

  // best candidate so far
  logic             best_found_q;
  logic [OSR_W-1:0] best_osr_q;
  logic [DB-1:0]    best_div_q;
  logic [CLK_W-1:0] best_err_q;
  logic             take;
  logic             nb_found;
  logic [OSR_W-1:0] nb_osr;
  logic [DB-1:0]    nb_div;
  logic [CLK_W-1:0] nb_err;

  always_comb begin
    take = e_ok_q && (e_first_q || !best_found_q || (e_err_q < best_err_q));
    if (take) begin
      nb_found = 1'b1;
      nb_osr   = e_osr_q;
      nb_div   = e_div_q;
      nb_err   = e_err_q;
    end else if (e_first_q) begin
      nb_found = 1'b0;
      nb_osr   = '0;
      nb_div   = '0;
      nb_err   = '0;
    end else begin
      nb_found = best_found_q;
      nb_osr   = best_osr_q;
      nb_div   = best_div_q;
      nb_err   = best_err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_found_q <= 1'b0;
    end else if (en && e_v_q) begin
      best_found_q <= nb_found;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && e_v_q) begin
      best_osr_q <= nb_osr;
      best_div_q <= nb_div;
      best_err_q <= nb_err;
    end
  end

  // output register
  logic [OSR_W-1:0]     out_osr_q;
  logic [DIV_OUT_W-1:0] out_div_q;
  logic [ERR_OUT_W-1:0] out_err_q;
  logic                 out_found_q;
  logic                 out_load;
  logic [DIV_OUT_W-1:0] nb_div_x;

  assign out_load = en && e_v_q && e_last_q;

  if (DB >= DIV_OUT_W) begin : g_div_trunc
    assign nb_div_x = nb_div[DIV_OUT_W-1:0];
  end else begin : g_div_ext
    assign nb_div_x = {{(DIV_OUT_W-DB){1'b0}}, nb_div};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_osr_q   <= nb_osr;
      out_div_q   <= nb_div_x;
      out_err_q   <= nb_err[ERR_OUT_W-1:0];
      out_found_q <= nb_found;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'd0, out_err_q, out_div_q, out_osr_q};
  assign m_axis_tuser  = out_found_q;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for uart_baud_divisor_search
// Drives baud rates through the input stream under several clock settings,
// predicts the best oversampling setting and divisor, and checks each result.
// ----------------------------------------------------------------------------
module tb;
  import ubd_pkg::*;

  localparam int unsigned DIV_MAX    = 8191;
  localparam int unsigned ERR_START  = 32'hFFFFFFF;
  localparam int unsigned DRAIN_CYC  = 120;
  localparam int unsigned N_RANDOM   = 1800;
  localparam int unsigned N_PHASES   = 6;

  typedef struct packed {
    logic [OSR_W-1:0]     osr;
    logic [DIV_OUT_W-1:0] div;
    logic [ERR_OUT_W-1:0] err;
    logic                 found;
  } search_res_t;

  typedef struct {
    logic [BAUD_W-1:0] baud;
    logic              known;
    search_res_t       res;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_wr_en_i;
  logic [CLK_W-1:0]     cfg_wr_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [47:0]          m_axis_tdata;
  logic                 m_axis_tuser;

  logic [CLK_W-1:0]     clock_setting;
  search_res_t          pending_q[$];
  int unsigned          fail_cnt;
  logic                 stall_mode;

  uart_baud_divisor_search dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_wr_en_i(cfg_wr_en_i), .cfg_wr_data_i(cfg_wr_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // best divisor search over all oversampling settings
  function automatic search_res_t best_divisor(logic [BAUD_W-1:0] baud,
                                               logic [CLK_W-1:0] clk_hz);
    search_res_t r;
    longint unsigned best_err, dv, ach, er, ratio;
    r = '0;
    best_err = ERR_START;
    if (baud != 0) begin
      for (int s = 7; s <= 31; s++) begin
        ratio = s + 1;
        dv = longint'(clk_hz) / (longint'(baud) * ratio);
        if (dv == 0 || dv > DIV_MAX) continue;
        ach = longint'(clk_hz) / (dv * ratio);
        er = (baud >= ach) ? baud - ach : ach - baud;
        if (er < best_err) begin
          best_err = er;
          r.osr = s[OSR_W-1:0];
          r.div = dv[DIV_OUT_W-1:0];
          r.err = er[ERR_OUT_W-1:0];
          r.found = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // receiver stall pattern: phases of no stalls and of heavy stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode    <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    search_res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction");
        fail_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        if (m_axis_tdata[4:0] !== exp_r.osr) begin
          $error("osr_setting exp %0d got %0d", exp_r.osr, m_axis_tdata[4:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[17:5] !== exp_r.div) begin
          $error("divisor exp %0d got %0d", exp_r.div, m_axis_tdata[17:5]);
          fail_cnt++;
        end
        if (m_axis_tdata[41:18] !== exp_r.err) begin
          $error("rate_error exp %0d got %0d", exp_r.err, m_axis_tdata[41:18]);
          fail_cnt++;
        end
        if (m_axis_tuser !== exp_r.found) begin
          $error("found exp %0d got %0d", exp_r.found, m_axis_tuser);
          fail_cnt++;
        end
      end
    end
  end

  // send one baud rate, queue its expected result
  task automatic send_baud(logic [BAUD_W-1:0] baud, logic known, search_res_t res);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= baud;
    pending_q.push_back(known ? res : best_divisor(baud, clock_setting));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // one idle gap of random length
  task automatic sender_gap(int unsigned max_gap);
    int unsigned n;
    n = $urandom_range(0, max_gap);
    if (n != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_clock(logic [CLK_W-1:0] v);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    clock_setting = v;
  endtask

  // random baud rate: mostly realistic rates, some wide and edge values
  function automatic logic [BAUD_W-1:0] rand_baud();
    case ($urandom_range(0, 9))
      0:       return BAUD_W'($urandom());
      1:       return BAUD_W'($urandom_range(0, 16));
      2:       return BAUD_W'($urandom_range(1, 10000000));
      3, 4:    return BAUD_W'($urandom_range(300, 2000));
      default: return BAUD_W'($urandom_range(1200, 1000000));
    endcase
  endfunction

  // stimulus
  initial begin
    stim_row_t rows[$];
    logic [CLK_W-1:0] clocks[N_PHASES];
    int unsigned burst;
    clocks = '{27'd1000000, 27'd100000000, 27'h7FFFFFF, 27'd0, 27'd3686400,
               27'd48000000};
    fail_cnt = 0;
    clock_setting = CLK_RESET;
    cfg_wr_en_i = 1'b0;
    cfg_wr_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under the reset clock
    rows.push_back('{24'd0,        1'b1, '0});                  // zero baud
    rows.push_back('{24'hFFFFFF,   1'b1, '0});                  // divisor truncates to 0
    rows.push_back('{24'd10000000, 1'b1, '0});
    rows.push_back('{24'd1,        1'b1, '0});                  // divisor too large
    rows.push_back('{24'd115200,   1'b0, '0});
    rows.push_back('{24'd9600,     1'b0, '0});
    rows.push_back('{24'd300,      1'b0, '0});
    rows.push_back('{24'd1000000,  1'b0, '0});
    rows.push_back('{24'd5000000,  1'b1, '{5'd7, 13'd1, 24'd0, 1'b1}});
    rows.push_back('{24'd155,      1'b0, '0});                  // near top divisor
    rows.push_back('{24'd170,      1'b0, '0});
    rows.push_back('{24'h555555,   1'b0, '0});
    rows.push_back('{24'hAAAAAA,   1'b0, '0});
    foreach (rows[i]) begin
      send_baud(rows[i].baud, rows[i].known, rows[i].res);
      sender_gap(3);
    end
    wait_idle();

    // random phases over several clock settings
    for (int p = 0; p <= N_PHASES; p++) begin
      if (p > 0) write_clock(clocks[p-1]);
      for (int i = 0; i < N_RANDOM / (N_PHASES + 1); ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst; b++) begin
          send_baud(rand_baud(), 1'b0, '0);
          i++;
        end
        sender_gap(($urandom_range(0, 3) == 0) ? 60 : 4);
      end
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("uart_baud_divisor_search: match");
    end else begin
      $display("uart_baud_divisor_search: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("uart_baud_divisor_search: mismatch");
    $finish;
  end

endmodule

FILE: filelist.f
src/ubd_pkg.sv
src/ubd_div_cell.sv
src/ubd_div_chain.sv
src/uart_baud_divisor_search.sv
tb/tb.sv
